// File: design/tccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_pkg
// Shared types, constants and codes of the text console cursor controller.
// ----------------------------------------------------------------------------
package tccc_pkg;

	// Glyph cell geometry and tab spacing
	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;
	localparam int TAB_CELLS    = 8;
	localparam int MAX_SCALE    = 15;

	// Field widths
	localparam int COORD_W = 12;
	localparam int COLOR_W = 24;
	localparam int SCALE_W = 4;
	localparam int REQ_W   = 4;
	localparam int CODE_W  = 8;
	localparam int ACT_W   = 3;
	localparam int CFG_IDX_W = 2;

	// Derived widths of the cell sizes and the tab step
	localparam int CW_W   = $clog2(MAX_SCALE * GLYPH_WIDTH + 1);
	localparam int CH_W   = $clog2(MAX_SCALE * GLYPH_HEIGHT + 1);
	localparam int STEP_W = $clog2(MAX_SCALE * GLYPH_WIDTH * TAB_CELLS + 1);
	// Working position width: a 12-bit position plus one cell or tab step
	localparam int POS_W  = $clog2((1 << COORD_W) - 1 + MAX_SCALE *
		((GLYPH_WIDTH * TAB_CELLS > GLYPH_HEIGHT) ? GLYPH_WIDTH * TAB_CELLS
		: GLYPH_HEIGHT) + 1);
	localparam int DIV_CNT_W = $clog2(COORD_W + 1);

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CHAR      = 4'd0;
	localparam logic [REQ_W-1:0] REQ_NEWLINE   = 4'd1;
	localparam logic [REQ_W-1:0] REQ_BACKSPACE = 4'd2;
	localparam logic [REQ_W-1:0] REQ_TAB       = 4'd3;
	localparam logic [REQ_W-1:0] REQ_LEFT      = 4'd4;
	localparam logic [REQ_W-1:0] REQ_RIGHT     = 4'd5;
	localparam logic [REQ_W-1:0] REQ_UP        = 4'd6;
	localparam logic [REQ_W-1:0] REQ_DOWN      = 4'd7;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd8;
	localparam logic [REQ_W-1:0] REQ_UNDERLINE = 4'd9;

	// Control characters
	localparam logic [CODE_W-1:0] CHR_NEWLINE   = 8'd10;
	localparam logic [CODE_W-1:0] CHR_BACKSPACE = 8'd8;
	localparam logic [CODE_W-1:0] CHR_TAB       = 8'd9;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_GLYPH     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SCROLL    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FILL      = 3'd4;
	localparam logic [ACT_W-1:0] ACT_UNDERLINE = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_SCALE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_COLOR   = 2'd3;

	// Underline sits this many rows above the cell bottom
	localparam int UNDERLINE_LIFT = 2;

	// One drawing command without the cursor and last fields
	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [CODE_W-1:0]  glyph_code;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COLOR_W-1:0] draw_fg;
		logic [COLOR_W-1:0] draw_bg;
	} cmd_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

// File: design/tccc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module tccc_div import tccc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [COORD_W-1:0]   dividend,
	input  logic [STEP_W-1:0]    divisor,
	output logic                 done,
	output logic [STEP_W-1:0]    remainder
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [COORD_W-1:0]   dvd_q;
	logic [STEP_W-1:0]    rem_q;
	logic                 done_q;
	logic [STEP_W:0]      trial;
	logic [STEP_W:0]      diff;

	// Bring down the next dividend bit and subtract where it fits
	assign trial = {rem_q, dvd_q[COORD_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(COORD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[STEP_W-1:0];
			end else begin
				rem_q <= trial[STEP_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: design/text_console_cursor_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_controller
// Console request sequencer: moves the pixel cursor and issues blitter commands.
// ----------------------------------------------------------------------------
// Sequencing: a taken request moves through ST_EXEC, which commits the cursor
// and registers the first command; a tab first waits in ST_DIV for the 12-step
// remainder divider that finds the tab stop. One request at a time: the next is
// taken in the cycle after the final command of the previous one leaves.
// Reset: cursor at 0,0, registers at 1024x768, scale 1, clear color 0.
// ----------------------------------------------------------------------------
module text_console_cursor_controller import tccc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [CODE_W-1:0]    char_code,
	input  logic [COLOR_W-1:0]   text_color,
	input  logic [COLOR_W-1:0]   back_color,
	// command channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ACT_W-1:0]     action,
	output logic [CODE_W-1:0]    glyph_code,
	output logic [COORD_W-1:0]   pos_x,
	output logic [COORD_W-1:0]   pos_y,
	output logic [COLOR_W-1:0]   draw_fg,
	output logic [COLOR_W-1:0]   draw_bg,
	output logic [COORD_W-1:0]   cursor_x,
	output logic [COORD_W-1:0]   cursor_y,
	output logic                 last
);

	// ---------------- configuration registers ----------------
	logic [COORD_W-1:0] screen_width_q;
	logic [COORD_W-1:0] screen_height_q;
	logic [SCALE_W-1:0] font_scale_q;
	logic [COLOR_W-1:0] clear_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= COORD_W'(1024);
			screen_height_q <= COORD_W'(768);
			font_scale_q    <= SCALE_W'(1);
			clear_color_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[COORD_W-1:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[COORD_W-1:0];
				CFG_FONT_SCALE:    font_scale_q    <= cfg_data[SCALE_W-1:0];
				CFG_CLEAR_COLOR:   clear_color_q   <= cfg_data;
			endcase
		end
	end

	// ---------------- cell geometry ----------------
	// A zero scale counts as one. The products are by small constants.
	logic [SCALE_W-1:0] scale_c;
	logic [CW_W-1:0]    cw_c;
	logic [CH_W-1:0]    ch_c;
	logic [STEP_W-1:0]  step_c;

	assign scale_c = (font_scale_q == '0) ? SCALE_W'(1) : font_scale_q;
	assign cw_c    = CW_W'(scale_c * GLYPH_WIDTH);
	assign ch_c    = CH_W'(scale_c * GLYPH_HEIGHT);
	assign step_c  = STEP_W'(scale_c * (GLYPH_WIDTH * TAB_CELLS));

	// ---------------- sequencer and request registers ----------------
	state_t              state_q;
	logic                accept;
	logic                emit_done;
	logic [REQ_W-1:0]    req_eff;
	logic [REQ_W-1:0]    req_q;
	logic [CODE_W-1:0]   code_q;
	logic [COLOR_W-1:0]  fg_q;
	logic [COLOR_W-1:0]  bg_q;
	logic [CW_W-1:0]     cw_q;
	logic [CH_W-1:0]     ch_q;
	logic [STEP_W-1:0]   step_q;
	logic [COORD_W-1:0]  cursor_col_q;
	logic [COORD_W-1:0]  cursor_row_q;
	logic                div_done;
	logic [STEP_W-1:0]   div_rem;

	// Take a request only with nothing in flight
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Fold the control characters into their own request types
	always_comb begin
		req_eff = req_type;
		if (req_type == REQ_CHAR) begin
			if (char_code == CHR_NEWLINE) begin
				req_eff = REQ_NEWLINE;
			end else if (char_code == CHR_BACKSPACE) begin
				req_eff = REQ_BACKSPACE;
			end else if (char_code == CHR_TAB) begin
				req_eff = REQ_TAB;
			end
		end
	end

	// Latch the request and freeze the geometry it sees
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_eff;
			code_q <= char_code;
			fg_q   <= text_color;
			bg_q   <= back_color;
			cw_q   <= cw_c;
			ch_q   <= ch_c;
			step_q <= step_c;
		end
	end

	// The tab stop needs the column modulo the tab step
	tccc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && (req_eff == REQ_TAB)),
		.dividend  (cursor_col_q),
		.divisor   (step_c),
		.done      (div_done),
		.remainder (div_rem)
	);

	// ---------------- cursor arithmetic ----------------
	// All compares run at full working width; results wrap to 12 bits.
	logic [POS_W-1:0]   wx, wy, wsw, wsh, wcw, wch;
	logic [POS_W-1:0]   sum_x, sum_y, tab_x, ul_y;
	logic               nl_scroll;
	logic [COORD_W-1:0] nl_y;
	logic               bw_ok;
	logic [COORD_W-1:0] bw_x, bw_y;
	cmd_t               cmd0, cmd_scroll, cmd_none;
	logic               two_cmds;
	logic [COORD_W-1:0] next_x, next_y;

	always_comb begin
		wx    = POS_W'(cursor_col_q);
		wy    = POS_W'(cursor_row_q);
		wsw   = POS_W'(screen_width_q);
		wsh   = POS_W'(screen_height_q);
		wcw   = POS_W'(cw_q);
		wch   = POS_W'(ch_q);
		sum_x = wx + wcw;
		sum_y = wy + wch;
		tab_x = wx - POS_W'(div_rem) + POS_W'(step_q);
		ul_y  = sum_y - POS_W'(UNDERLINE_LIFT);

		// Newline: step down, or pin to the last full row and scroll
		nl_scroll = (sum_y >= wsh);
		if (!nl_scroll) begin
			nl_y = sum_y[COORD_W-1:0];
		end else if (wsh >= wch) begin
			nl_y = COORD_W'(wsh - wch);
		end else begin
			nl_y = '0;
		end

		// Reverse wrap to the end of the previous row
		bw_ok = 1'b1;
		bw_x  = cursor_col_q;
		bw_y  = cursor_row_q;
		if (wx >= wcw) begin
			bw_x = COORD_W'(wx - wcw);
		end else if (wy >= wch) begin
			bw_y = COORD_W'(wy - wch);
			bw_x = (wsw >= wcw) ? COORD_W'(wsw - wcw) : '0;
		end else begin
			bw_ok = 1'b0;
		end
	end

	always_comb begin
		cmd_none   = '0;
		cmd_scroll = '0;
		cmd_scroll.action  = ACT_SCROLL;
		cmd_scroll.draw_bg = clear_color_q;

		cmd0     = cmd_none;
		two_cmds = 1'b0;
		next_x   = cursor_col_q;
		next_y   = cursor_row_q;

		case (req_q)
			REQ_CHAR: begin
				cmd0.action     = ACT_GLYPH;
				cmd0.glyph_code = code_q;
				cmd0.pos_x      = cursor_col_q;
				cmd0.pos_y      = cursor_row_q;
				cmd0.draw_fg    = fg_q;
				cmd0.draw_bg    = bg_q;
				if (sum_x >= wsw) begin
					next_x   = '0;
					next_y   = nl_y;
					two_cmds = nl_scroll;
				end else begin
					next_x = sum_x[COORD_W-1:0];
				end
			end
			REQ_NEWLINE: begin
				next_x = '0;
				next_y = nl_y;
				if (nl_scroll) begin
					cmd0 = cmd_scroll;
				end
			end
			REQ_BACKSPACE: begin
				next_x = bw_x;
				next_y = bw_y;
				if (bw_ok) begin
					cmd0.action  = ACT_CLEAR;
					cmd0.pos_x   = bw_x;
					cmd0.pos_y   = bw_y;
					cmd0.draw_bg = clear_color_q;
				end
			end
			REQ_TAB: begin
				if (tab_x >= wsw) begin
					next_x = '0;
					next_y = nl_y;
					if (nl_scroll) begin
						cmd0 = cmd_scroll;
					end
				end else begin
					next_x = tab_x[COORD_W-1:0];
				end
			end
			REQ_LEFT: begin
				next_x = bw_x;
				next_y = bw_y;
			end
			REQ_RIGHT: begin
				if (sum_x < wsw) begin
					next_x = sum_x[COORD_W-1:0];
				end else if (sum_y < wsh) begin
					next_x = '0;
					next_y = sum_y[COORD_W-1:0];
				end
			end
			REQ_UP: begin
				if (wy >= wch) begin
					next_y = COORD_W'(wy - wch);
				end
			end
			REQ_DOWN: begin
				if (sum_y < wsh) begin
					next_y = sum_y[COORD_W-1:0];
				end
			end
			REQ_CLEAR: begin
				next_x       = '0;
				next_y       = '0;
				cmd0.action  = ACT_FILL;
				cmd0.draw_bg = bg_q;
			end
			REQ_UNDERLINE: begin
				cmd0.action  = ACT_UNDERLINE;
				cmd0.pos_x   = cursor_col_q;
				cmd0.pos_y   = ul_y[COORD_W-1:0];
				cmd0.draw_fg = fg_q;
			end
			default: begin
				// unknown request: drop, emit a single empty command
			end
		endcase
	end

	// ---------------- output register and sequencing ----------------
	cmd_t out_cmd_q;
	cmd_t pend_cmd_q;
	logic pend_q;
	logic out_valid_q;
	logic last_q;

	assign emit_done = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req_eff == REQ_TAB) ? ST_DIV : ST_EXEC;
					end
				end
				ST_DIV: begin
					// hold until the remainder settles
					if (div_done) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// commit the cursor and present the first command
					cursor_col_q <= next_x;
					cursor_row_q <= next_y;
					out_valid_q  <= 1'b1;
					last_q       <= !two_cmds;
					pend_q       <= two_cmds;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_done) begin
						if (pend_q) begin
							// advance to the trailing scroll command
							pend_q <= 1'b0;
							last_q <= 1'b1;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			out_cmd_q  <= cmd0;
			pend_cmd_q <= cmd_scroll;
		end else if (state_q == ST_EMIT && emit_done && pend_q) begin
			out_cmd_q <= pend_cmd_q;
		end
	end

	// Every command of a request carries the cursor after the whole request
	assign out_valid  = out_valid_q;
	assign action     = out_cmd_q.action;
	assign glyph_code = out_cmd_q.glyph_code;
	assign pos_x      = out_cmd_q.pos_x;
	assign pos_y      = out_cmd_q.pos_y;
	assign draw_fg    = out_cmd_q.draw_fg;
	assign draw_bg    = out_cmd_q.draw_bg;
	assign cursor_x   = cursor_col_q;
	assign cursor_y   = cursor_row_q;
	assign last       = last_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cursor controller. Drives console
// requests with random gaps, stalls the command side at random, predicts each
// blitter command and the cursor from a behavioral model kept in the bench,
// and compares every accepted command field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import tccc_pkg::*;

	// Expected command: blitter fields plus the cursor after the request
	typedef struct packed {
		cmd_t               cmd;
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic               last_flag;
	} cmd_record_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
	logic [COLOR_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [REQ_W-1:0]   req_type = REQ_CHAR;
	logic [CODE_W-1:0]  char_code = '0;
	logic [COLOR_W-1:0] text_color = '0;
	logic [COLOR_W-1:0] back_color = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [ACT_W-1:0]   action;
	logic [CODE_W-1:0]  glyph_code;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic [COLOR_W-1:0] draw_fg;
	logic [COLOR_W-1:0] draw_bg;
	logic [COORD_W-1:0] cursor_x;
	logic [COORD_W-1:0] cursor_y;
	logic               last;

	// Bench copy of the registers and the cursor, at their reset values
	logic [COORD_W-1:0] scr_w = 12'd1024;
	logic [COORD_W-1:0] scr_h = 12'd768;
	logic [SCALE_W-1:0] cell_scale = 4'd1;
	logic [COLOR_W-1:0] erase_color = '0;
	logic [COORD_W-1:0] cur_col = '0;
	logic [COORD_W-1:0] cur_row = '0;

	cmd_record_t blitter_cmds_due [$];
	int          error_count = 0;
	bit          send_idle = 1'b1;
	bit          recv_idle = 1'b1;

	text_console_cursor_controller u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.text_color (text_color),
		.back_color (back_color),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.glyph_code (glyph_code),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.draw_fg    (draw_fg),
		.draw_bg    (draw_bg),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.last       (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Cursor model
	// ------------------------------------------------------------------

	function automatic cmd_t make_cmd(input logic [ACT_W-1:0] act,
			input logic [CODE_W-1:0] glyph, input int unsigned px,
			input int unsigned py, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg);
		cmd_t c;
		c.action     = act;
		c.glyph_code = glyph;
		c.pos_x      = COORD_W'(px);
		c.pos_y      = COORD_W'(py);
		c.draw_fg    = fg;
		c.draw_bg    = bg;
		return c;
	endfunction

	// Move to the start of the next text row; return 1 when the screen scrolls
	function automatic bit line_feed(inout int unsigned cx, inout int unsigned cy,
			input int unsigned ch);
		cx = 0;
		if (cy + ch < scr_h) begin
			cy = cy + ch;
			return 1'b0;
		end
		// pin to the last full row, or the top if no row fits
		cy = (scr_h >= ch) ? scr_h - ch : 0;
		return 1'b1;
	endfunction

	// Step back one cell, wrapping to the end of the previous row
	function automatic bit step_back(inout int unsigned cx, inout int unsigned cy,
			input int unsigned cw, input int unsigned ch);
		if (cx >= cw) begin
			cx = cx - cw;
			return 1'b1;
		end
		if (cy >= ch) begin
			cy = cy - ch;
			cx = (scr_w >= cw) ? scr_w - cw : 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Work out the commands of one accepted request and queue them
	function automatic void predict_commands(input logic [REQ_W-1:0] rq,
			input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg);
		int unsigned sc, cw, ch, cx, cy, stp;
		logic [REQ_W-1:0] op;
		cmd_t cmds [2];
		int n;
		int i;
		cmd_record_t rec;
		sc = (cell_scale == 0) ? 1 : cell_scale;
		cw = GLYPH_WIDTH * sc;
		ch = GLYPH_HEIGHT * sc;
		cx = cur_col;
		cy = cur_row;
		n = 0;
		op = rq;
		// control bytes sent as characters act as their request
		if (op == REQ_CHAR) begin
			if (code == CHR_NEWLINE)
				op = REQ_NEWLINE;
			else if (code == CHR_BACKSPACE)
				op = REQ_BACKSPACE;
			else if (code == CHR_TAB)
				op = REQ_TAB;
		end
		case (op)
		REQ_CHAR: begin
			cmds[n] = make_cmd(ACT_GLYPH, code, cx, cy, fg, bg);
			n++;
			// the advance is tested at full width, before truncation
			cx = cx + cw;
			if (cx >= scr_w) begin
				if (line_feed(cx, cy, ch)) begin
					cmds[n] = make_cmd(ACT_SCROLL, '0, 0, 0, '0, erase_color);
					n++;
				end
			end
		end
		REQ_NEWLINE: begin
			if (line_feed(cx, cy, ch)) begin
				cmds[n] = make_cmd(ACT_SCROLL, '0, 0, 0, '0, erase_color);
				n++;
			end
		end
		REQ_BACKSPACE: begin
			if (step_back(cx, cy, cw, ch)) begin
				cmds[n] = make_cmd(ACT_CLEAR, '0, cx, cy, '0, erase_color);
				n++;
			end
		end
		REQ_TAB: begin
			stp = cw * TAB_CELLS;
			cx = (cx / stp + 1) * stp;
			if (cx >= scr_w) begin
				if (line_feed(cx, cy, ch)) begin
					cmds[n] = make_cmd(ACT_SCROLL, '0, 0, 0, '0, erase_color);
					n++;
				end
			end
		end
		REQ_LEFT: begin
			void'(step_back(cx, cy, cw, ch));
		end
		REQ_RIGHT: begin
			if (cx + cw < scr_w) begin
				cx = cx + cw;
			end else if (cy + ch < scr_h) begin
				cx = 0;
				cy = cy + ch;
			end
		end
		REQ_UP: begin
			if (cy >= ch)
				cy = cy - ch;
		end
		REQ_DOWN: begin
			if (cy + ch < scr_h)
				cy = cy + ch;
		end
		REQ_CLEAR: begin
			cx = 0;
			cy = 0;
			cmds[n] = make_cmd(ACT_FILL, '0, 0, 0, '0, bg);
			n++;
		end
		REQ_UNDERLINE: begin
			cmds[n] = make_cmd(ACT_UNDERLINE, '0, cx, cy + ch - UNDERLINE_LIFT, fg, '0);
			n++;
		end
		default: ;
		endcase
		// nothing drawn: a single empty command still reports the cursor
		if (n == 0) begin
			cmds[n] = make_cmd(ACT_NONE, '0, 0, 0, '0, '0);
			n++;
		end
		cur_col = COORD_W'(cx);
		cur_row = COORD_W'(cy);
		for (i = 0; i < n; i++) begin
			rec.cmd       = cmds[i];
			rec.cur_x     = cur_col;
			rec.cur_y     = cur_row;
			rec.last_flag = (i == n - 1);
			blitter_cmds_due.push_back(rec);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request and configuration drivers
	// ------------------------------------------------------------------

	// Present one request, after a random gap when send_idle is set, and hold it until taken.
	// Valid stays high on return so a back-to-back request needs no toggle.
	task automatic send_request(input logic [REQ_W-1:0] rq,
			input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg);
		int gap;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		char_code  <= code;
		text_color <= fg;
		back_color <= bg;
		do
			@(posedge clk);
		while (in_stall);
		predict_commands(rq, code, fg, bg);
	endtask

	// Drop valid, wait for every expected command, then let the block settle
	task automatic drain_commands();
		in_valid <= 1'b0;
		while (blitter_cmds_due.size() != 0)
			@(posedge clk);
		// a tab takes the longest; leave room for any stray command
		repeat (20) @(posedge clk);
	endtask

	// Write all four registers back to back; call only while idle
	task automatic set_screen(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
			input logic [SCALE_W-1:0] s, input logic [COLOR_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= COLOR_W'(w);
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= COLOR_W'(h);
		@(posedge clk);
		cfg_index <= CFG_FONT_SCALE;
		cfg_data  <= COLOR_W'(s);
		@(posedge clk);
		cfg_index <= CFG_CLEAR_COLOR;
		cfg_data  <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_w       = w;
		scr_h       = h;
		cell_scale  = s;
		erase_color = c;
	endtask

	// ------------------------------------------------------------------
	// Command side: random stall and checking
	// ------------------------------------------------------------------

	// Draw a stall length per command, then hold stall low until one is taken
	initial begin : command_stall
		int gap;
		forever begin
			gap = recv_idle ? $urandom_range(0, 11) : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(arst_n && out_valid && !out_stall));
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_commands
		cmd_record_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (blitter_cmds_due.size() == 0) begin
				$error("unexpected command: action 0x%0h", action);
				error_count++;
			end else begin
				want = blitter_cmds_due.pop_front();
				check_field("action", want.cmd.action, action);
				check_field("glyph_code", want.cmd.glyph_code, glyph_code);
				check_field("pos_x", want.cmd.pos_x, pos_x);
				check_field("pos_y", want.cmd.pos_y, pos_y);
				check_field("draw_fg", want.cmd.draw_fg, draw_fg);
				check_field("draw_bg", want.cmd.draw_bg, draw_bg);
				check_field("cursor_x", want.cur_x, cursor_x);
				check_field("cursor_y", want.cur_y, cursor_y);
				check_field("last", want.last_flag, last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every request type once at the reset geometry, with color extremes
	task automatic test_basic_requests();
		send_request(REQ_CHAR, 8'hFF, 24'hFFFFFF, 24'h000000);
		send_request(REQ_CHAR, 8'h00, 24'h000000, 24'hFFFFFF);
		send_request(REQ_CHAR, CHR_NEWLINE, 24'h123456, 24'h654321);
		send_request(REQ_CHAR, CHR_TAB, 24'hAAAAAA, 24'h555555);
		send_request(REQ_CHAR, CHR_BACKSPACE, 24'h555555, 24'hAAAAAA);
		send_request(REQ_NEWLINE, 8'h41, 24'hFFFFFF, 24'hFFFFFF);
		send_request(REQ_TAB, 8'h42, 24'h0, 24'h0);
		send_request(REQ_BACKSPACE, 8'h43, 24'h0F0F0F, 24'hF0F0F0);
		send_request(REQ_RIGHT, 8'h00, 24'h0, 24'h0);
		send_request(REQ_LEFT, 8'h00, 24'h0, 24'h0);
		send_request(REQ_DOWN, 8'h00, 24'h0, 24'h0);
		send_request(REQ_UP, 8'h00, 24'h0, 24'h0);
		send_request(REQ_UNDERLINE, 8'h7E, 24'hFFFFFF, 24'hFFFFFF);
		send_request(REQ_CLEAR, 8'h00, 24'h000000, 24'hFFFFFF);
		// unknown request types move nothing and yield one empty command
		send_request(REQ_UNDERLINE + 4'd1, 8'h5A, 24'h111111, 24'h222222);
		send_request(4'hF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
	endtask

	// Push the advance and the underline row past 4095 on the largest screen
	task automatic test_position_overflow();
		int k;
		drain_commands();
		set_screen(12'd4095, 12'd4095, 4'd1, 24'hFFFFFF);
		send_request(REQ_CHAR, CHR_NEWLINE, 24'h0, 24'h0);
		// reverse wrap parks the cursor one cell from the right edge
		send_request(REQ_LEFT, 8'h00, 24'h0, 24'h0);
		drain_commands();
		set_screen(12'd4095, 12'd4095, 4'd15, 24'h0000FF);
		// a large cell now carries the advance past 12 bits
		send_request(REQ_CHAR, 8'h57, 24'hFF00FF, 24'h00FF00);
		for (k = 0; k < 16; k++)
			send_request(REQ_NEWLINE, 8'h00, 24'h0, 24'h0);
		send_request(REQ_UNDERLINE, 8'h00, 24'hABCDEF, 24'h0);
		// pin the cursor to the lowest small row, then enlarge the cell
		drain_commands();
		set_screen(12'd4095, 12'd4095, 4'd1, 24'h00FF00);
		for (k = 0; k < 16; k++)
			send_request(REQ_NEWLINE, 8'h00, 24'h0, 24'h0);
		drain_commands();
		set_screen(12'd4095, 12'd4095, 4'd15, 24'hFF0000);
		send_request(REQ_UNDERLINE, 8'h00, 24'h13579B, 24'h0);
	endtask

	// Fixed geometry in the first phases, then random; mostly characters with control mixed in
	task automatic test_random_phases();
		logic [COORD_W-1:0] w, h;
		logic [SCALE_W-1:0] s;
		logic [REQ_W-1:0]   rq;
		logic [CODE_W-1:0]  code;
		logic [1:0]         idle_mode;
		int ph, k, pick;
		for (ph = 0; ph < 13; ph++) begin
			drain_commands();
			case (ph)
			0: begin
				// smallest legal screen: one cell wide, one row high
				w = 12'd8;
				h = 12'd16;
				s = 4'd1;
			end
			1: begin
				w = 12'd4095;
				h = 12'd4095;
				s = 4'd15;
			end
			2: begin
				// degenerate: no room at all, zero scale taken as one
				w = 12'd0;
				h = 12'd0;
				s = 4'd0;
			end
			3: begin
				// narrower than a cell: reverse wrap lands on column 0
				w = 12'd4;
				h = 12'd300;
				s = 4'd1;
			end
			4: begin
				w = 12'd200;
				h = 12'd160;
				s = 4'd8;
			end
			default: begin
				w = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 4095))
					: COORD_W'($urandom_range(8, 400));
				h = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 4095))
					: COORD_W'($urandom_range(16, 400));
				s = SCALE_W'($urandom_range(0, 15));
			end
			endcase
			set_screen(w, h, s, COLOR_W'($urandom_range(0, 24'hFFFFFF)));
			// both busy, one side idling, or both idling
			idle_mode = 2'($urandom_range(0, 3));
			send_idle = idle_mode[0];
			recv_idle = idle_mode[1];
			for (k = 0; k < 150; k++) begin
				pick = $urandom_range(0, 99);
				code = CODE_W'($urandom_range(0, 255));
				if (pick < 55) begin
					rq = REQ_CHAR;
				end else if (pick < 63) begin
					rq = REQ_CHAR;
					case ($urandom_range(0, 2))
					0: code = CHR_NEWLINE;
					1: code = CHR_BACKSPACE;
					default: code = CHR_TAB;
					endcase
				end else if (pick < 95) begin
					rq = REQ_W'($urandom_range(REQ_NEWLINE, REQ_UNDERLINE));
				end else begin
					rq = REQ_W'($urandom_range(REQ_UNDERLINE + 1, 15));
				end
				send_request(rq, code, COLOR_W'($urandom_range(0, 24'hFFFFFF)),
					COLOR_W'($urandom_range(0, 24'hFFFFFF)));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_position_overflow();
		test_random_phases();
		drain_commands();
		if (error_count == 0)
			$display("text_console_cursor_controller test passed");
		else
			$display("text_console_cursor_controller test failed");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#5000000;
		$display("text_console_cursor_controller test failed");
		$finish;
	end

endmodule
